@@ src/ebn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_pkg
// Shared constants, record types and state encodings of the band energy
// normalizer.
// ----------------------------------------------------------------------------
package ebn_pkg;

	localparam int NUM_BANDS     = 32;
	localparam int MAX_BAND_BINS = 64;
	localparam int SAMPLE_BITS   = 24;

	localparam int BAND_W  = $clog2(NUM_BANDS);
	localparam int CNT_W   = $clog2(MAX_BAND_BINS + 1);
	localparam int PSQ_W   = 2 * SAMPLE_BITS - 1;
	localparam int PW_W    = 2 * SAMPLE_BITS;
	localparam int ACC_W   = 64;
	localparam int MEAN_W  = 24;
	localparam int FEAT_W  = 16;
	localparam int SF_W    = 16;
	localparam int LOG_W   = 22;
	localparam int BNUM_W  = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int DB_FLOOR   = -1638400;
	localparam int DB_MAX     = 8388607;
	localparam int DB_MIN     = -8388608;
	localparam int TEN_LOG2   = 49321;
	localparam int LOG_BIAS   = (2 * (SAMPLE_BITS - 1)) * 65536;
	localparam int FEAT_MAX   = 32767;
	localparam int FEAT_MIN   = -32768;
	localparam int DIV_BIAS   = 160 * 1048576;
	localparam int FEAT_OFS   = 1048576;
	localparam int DIV_BITS   = 23;
	localparam int RECIP_5    = 13421773;  // ceil(2^26 / 5), exact below 2^26
	localparam int RECIP_SH   = 26;
	localparam int SF_RESET   = 64880;

	typedef struct packed {
		logic [ACC_W-1:0]  psum;
		logic [CNT_W-1:0]  cnt;
		logic [BAND_W-1:0] band;
		logic              fend;
	} band_rec_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOGP, S_LOGC, S_DB, S_SM1, S_SM2, S_FPREP, S_DIV, S_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		L_IDLE, L_NORM, L_SQR, L_DONE
	} log_state_t;

	typedef logic [NUM_BANDS-1:0][MEAN_W-1:0] mean_tab_t;

	// linspace -60 dB .. -90 dB in Q9.14, rounded
	function automatic mean_tab_t mean_table();
		mean_tab_t t;
		longint    step;
		for (int e = 0; e < NUM_BANDS; e++) begin
			step = (64'sd491520 * e + (NUM_BANDS - 1) / 2) / (NUM_BANDS - 1);
			t[e] = MEAN_W'(-64'sd983040 - step);
		end
		return t;
	endfunction

	localparam mean_tab_t MEAN_INIT = mean_table();

endpackage

@@ src/ebn_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_if
// Valid/ready channels for spectrum bins and band features.
// ----------------------------------------------------------------------------
interface ebn_bin_if;
	import ebn_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] real_part;
	logic signed [SAMPLE_BITS-1:0] imag_part;
	logic                          band_end;
	logic                          frame_end;
	modport source (output valid, real_part, imag_part, band_end, frame_end, input ready);
	modport sink (input valid, real_part, imag_part, band_end, frame_end, output ready);
endinterface

interface ebn_feat_if;
	import ebn_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [FEAT_W-1:0] feature;
	logic [BNUM_W-1:0]        band_number;
	logic                     last_of_frame;
	modport source (output valid, feature, band_number, last_of_frame, input ready);
	modport sink (input valid, feature, band_number, last_of_frame, output ready);
endinterface

@@ src/ebn_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module ebn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/ebn_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_fifo
// Short queue of closed band records between front and back.
// ----------------------------------------------------------------------------
module ebn_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ebn_pkg::band_rec_t push_data,
	output logic               full,
	input  logic               pop,
	output ebn_pkg::band_rec_t pop_data,
	output logic               empty
);
	import ebn_pkg::*;

	band_rec_t          buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full     = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = buf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ src/ebn_log2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_log2
// Iterative log2 in Q16: six normalize steps, then sixteen squarings.
// ----------------------------------------------------------------------------
module ebn_log2 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ebn_pkg::ACC_W-1:0]   value,
	output logic                        busy,
	output logic                        done,
	output logic [ebn_pkg::LOG_W-1:0]   result
);
	import ebn_pkg::*;

	log_state_t  state_q, state_d;
	logic [63:0] v_q, v_d;
	logic [5:0]  p_q, p_d;
	logic [2:0]  step_q;
	logic [30:0] m_q;
	logic [3:0]  i_q;
	logic [15:0] r_q;
	logic [61:0] sq;
	logic [31:0] sq_top;

	assign sq     = 62'(m_q) * 62'(m_q);
	assign sq_top = sq[61:30];
	assign busy   = (state_q == L_NORM) || (state_q == L_SQR);
	assign done   = (state_q == L_DONE);
	assign result = {p_q, r_q};

	// one binary-search shift step of the normalization
	always_comb begin
		v_d = v_q;
		p_d = p_q;
		case (step_q)
			3'd0: if (v_q[63:32] == '0) begin v_d = v_q << 32; p_d = p_q - 6'd32; end
			3'd1: if (v_q[63:48] == '0) begin v_d = v_q << 16; p_d = p_q - 6'd16; end
			3'd2: if (v_q[63:56] == '0) begin v_d = v_q << 8;  p_d = p_q - 6'd8;  end
			3'd3: if (v_q[63:60] == '0) begin v_d = v_q << 4;  p_d = p_q - 6'd4;  end
			3'd4: if (v_q[63:62] == '0) begin v_d = v_q << 2;  p_d = p_q - 6'd2;  end
			3'd5: if (!v_q[63]) begin v_d = v_q << 1; p_d = p_q - 6'd1; end
			default: begin
				v_d = v_q;
				p_d = p_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE, L_DONE: if (start) state_d = L_NORM;
				else state_d = L_IDLE;
			L_NORM: if (step_q == 3'd5) state_d = L_SQR;
			L_SQR:  if (i_q == '0) state_d = L_DONE;
			default: state_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result holds until the next start
	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE, L_DONE: if (start) begin
				v_q    <= value;
				p_q    <= 6'd63;
				step_q <= '0;
				i_q    <= 4'd15;
				r_q    <= '0;
			end
			L_NORM: begin
				v_q    <= v_d;
				p_q    <= p_d;
				step_q <= step_q + 1'b1;
				m_q    <= v_d[63:33];
			end
			L_SQR: begin
				if (sq_top[31]) begin
					m_q      <= sq_top[31:1];
					r_q[i_q] <= 1'b1;
				end else begin
					m_q <= sq_top[30:0];
				end
				i_q <= i_q - 1'b1;
			end
			default: ;
		endcase
	end
endmodule

@@ src/ebn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_front
// Squares incoming bins, accumulates band power and bin count, and queues
// a record for every closed band.
// ----------------------------------------------------------------------------
module ebn_front (
	input  logic               clk,
	input  logic               arst_n,
	ebn_bin_if.sink            bin_in,
	output logic               push,
	output ebn_pkg::band_rec_t push_data,
	input  logic               full
);
	import ebn_pkg::*;

	logic signed [PW_W-1:0] re_sq, im_sq;
	logic                   valid_s1, bend_s1, fend_s1;
	logic [PSQ_W-1:0]       re2_s1, im2_s1;
	logic [ACC_W-1:0]       acc_q, acc_new;
	logic [CNT_W-1:0]       cnt_q, cnt_new;
	logic [BAND_W-1:0]      band_q;
	logic [PW_W-1:0]        pw;
	logic [ACC_W:0]         sum;
	logic                   advance;

	assign re_sq = bin_in.real_part * bin_in.real_part;
	assign im_sq = bin_in.imag_part * bin_in.imag_part;

	assign advance      = valid_s1 && (!bend_s1 || !full);
	assign bin_in.ready = !valid_s1 || advance;

	assign pw      = {1'b0, re2_s1} + {1'b0, im2_s1};
	assign sum     = {1'b0, acc_q} + (ACC_W + 1)'(pw);
	assign acc_new = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	assign cnt_new = (cnt_q == CNT_W'(MAX_BAND_BINS)) ? cnt_q : cnt_q + 1'b1;

	assign push           = advance && bend_s1;
	assign push_data.psum = acc_new;
	assign push_data.cnt  = cnt_new;
	assign push_data.band = band_q;
	assign push_data.fend = fend_s1;

	always_ff @(posedge clk) begin
		if (bin_in.valid && bin_in.ready) begin
			re2_s1  <= re_sq[PSQ_W-1:0];
			im2_s1  <= im_sq[PSQ_W-1:0];
			bend_s1 <= bin_in.band_end || bin_in.frame_end;
			fend_s1 <= bin_in.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			cnt_q    <= '0;
			band_q   <= '0;
		end else begin
			if (bin_in.ready) valid_s1 <= bin_in.valid;
			if (advance) begin
				if (bend_s1) begin
					acc_q <= '0;
					cnt_q <= '0;
					if (fend_s1 || band_q == BAND_W'(NUM_BANDS - 1)) band_q <= '0;
					else band_q <= band_q + 1'b1;
				end else begin
					acc_q <= acc_new;
					cnt_q <= cnt_new;
				end
			end
		end
	end
endmodule

@@ src/ebn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebn_back
// Per-band sequencer: log of mean power, dB, running mean, feature.
// ----------------------------------------------------------------------------
module ebn_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ebn_pkg::SF_W-1:0] smooth_factor,
	output logic                     pop,
	input  ebn_pkg::band_rec_t       pop_data,
	input  logic                     empty,
	ebn_feat_if.source               feat
);
	import ebn_pkg::*;

	back_state_t              state_q, state_d;
	band_rec_t                rec_q;
	logic [LOG_W-1:0]         lp_q;
	logic                     log_start, log_busy, log_done;
	logic [ACC_W-1:0]         log_value;
	logic [LOG_W-1:0]         log_result;
	logic signed [23:0]       lg;
	logic signed [24:0]       mul_a;
	logic signed [17:0]       mul_b;
	logic signed [42:0]       prod, acc_q, dbs;
	logic signed [43:0]       sm_sum, nms;
	logic signed [MEAN_W-1:0] db_q, nm_q, nm_d, db_d, mean_sel;
	logic [MEAN_W-1:0]        ram_rdata;
	logic                     ram_we;
	logic [NUM_BANDS-1:0]     mvalid_q;
	logic [28:0]              z;
	logic [DIV_BITS-1:0]      w_q, qn;
	logic [DIV_BITS+23:0]     qprod;
	logic signed [23:0]       fv;
	logic signed [FEAT_W-1:0] feat_q;

	ebn_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.value  (log_value),
		.busy   (log_busy),
		.done   (log_done),
		.result (log_result)
	);

	ebn_ram #(.WIDTH(MEAN_W), .DEPTH(NUM_BANDS)) u_mean (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rec_q.band),
		.wdata (nm_d),
		.raddr (rec_q.band),
		.rdata (ram_rdata)
	);

	assign mean_sel = mvalid_q[rec_q.band] ? $signed(ram_rdata)
		: $signed(MEAN_INIT[rec_q.band]);

	assign lg = $signed({2'b0, lp_q}) - $signed({2'b0, log_result}) - 24'(LOG_BIAS);

	always_comb begin
		case (state_q)
			S_DB:    begin mul_a = 25'(lg);       mul_b = 18'(TEN_LOG2); end
			S_SM1:   begin mul_a = 25'(db_q);     mul_b = $signed(18'(17'h10000 - 17'(smooth_factor))); end
			S_SM2:   begin mul_a = 25'(mean_sel); mul_b = $signed({2'b0, smooth_factor}); end
			default: begin mul_a = '0;            mul_b = '0; end
		endcase
	end
	assign prod = mul_a * mul_b;

	// dB with floor and upper clamp
	assign dbs = (prod + 43'sd32768) >>> 16;
	always_comb begin
		if (rec_q.psum == '0 || dbs < DB_FLOOR) db_d = MEAN_W'(DB_FLOOR);
		else if (dbs > DB_MAX) db_d = MEAN_W'(DB_MAX);
		else db_d = dbs[MEAN_W-1:0];
	end

	// smoothed mean with rounding and clamp
	assign sm_sum = 44'(acc_q) + 44'(prod) + 44'sd32768;
	assign nms    = sm_sum >>> 16;
	always_comb begin
		if (nms > DB_MAX) nm_d = MEAN_W'(DB_MAX);
		else if (nms < DB_MIN) nm_d = MEAN_W'(DB_MIN);
		else nm_d = nms[MEAN_W-1:0];
	end

	// floor((x + 80) / 160) as floor(biased / 32) / 5, by reciprocal multiplication
	assign z     = 29'(db_q) - 29'(nm_q) + 29'(80 + DIV_BIAS);
	assign qprod = (DIV_BITS + 24)'(w_q) * (DIV_BITS + 24)'(RECIP_5);
	assign qn    = DIV_BITS'(qprod >> RECIP_SH);
	assign fv    = $signed({1'b0, qn}) - 24'(FEAT_OFS);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		log_start = 1'b0;
		log_value = rec_q.psum;
		ram_we    = 1'b0;
		case (state_q)
			S_IDLE: if (!empty) begin
				pop       = 1'b1;
				log_start = 1'b1;
				log_value = pop_data.psum;
				state_d   = S_LOGP;
			end
			S_LOGP: if (log_done) begin
				log_start = 1'b1;
				log_value = ACC_W'(rec_q.cnt);
				state_d   = S_LOGC;
			end
			S_LOGC:  if (log_done) state_d = S_DB;
			S_DB:    state_d = S_SM1;
			S_SM1:   state_d = S_SM2;
			S_SM2: begin
				ram_we  = 1'b1;
				state_d = S_FPREP;
			end
			S_FPREP: state_d = S_DIV;
			S_DIV:   state_d = S_OUT;
			S_OUT:   if (feat.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign feat.valid         = (state_q == S_OUT);
	assign feat.feature       = feat_q;
	assign feat.band_number   = BNUM_W'(rec_q.band);
	assign feat.last_of_frame = rec_q.fend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mvalid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) mvalid_q[rec_q.band] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) rec_q <= pop_data;
		case (state_q)
			S_LOGP:  if (log_done) lp_q <= log_result;
			S_DB:    db_q <= db_d;
			S_SM1:   acc_q <= prod;
			S_SM2:   nm_q <= nm_d;
			S_FPREP: w_q <= z[27:5];
			S_DIV: begin
				if (fv > FEAT_MAX) feat_q <= FEAT_W'(FEAT_MAX);
				else if (fv < FEAT_MIN) feat_q <= FEAT_W'(FEAT_MIN);
				else feat_q <= fv[FEAT_W-1:0];
			end
			default: ;
		endcase
	end

	a_log_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		log_start |-> !log_busy) else $error("log unit restarted while busy");
	a_mean_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> mvalid_q[rec_q.band]) else $error("band mean not marked written");
	a_db_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SM1) |-> (db_q >= DB_FLOOR)) else $error("dB below floor");
endmodule

@@ src/erb_band_energy_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erb_band_energy_normalizer
// Band log-energy with running mean normalization over a stream of bins.
// ----------------------------------------------------------------------------
// Bins are taken one per cycle on bin_in; each adds re^2+im^2 to the band
// power and counts one bin. A bin with band_end or frame_end closes the band
// and the band record goes into a four-deep queue, so bins keep flowing while
// the back end works. When the feature beat is taken at once, the back end
// handles each band as: a pop, two runs of the shared log2 unit (6 normalize
// steps, 16 squarings and a done state each), three multiply steps for dB and
// smoothing, a setup step and a reciprocal multiply for the division by 160,
// and the output beat. Input stalls only when the queue is full, so bands no
// shorter in bins than the back end's time per band stream at one bin per
// cycle. Running means start at -60..-90 dB and smooth_factor (APB offset 0,
// reset 64880) is the smoothing alpha in Q0.16; write it only while the block
// is idle.
module erb_band_energy_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ebn_bin_if.sink     bin_in,
	ebn_feat_if.source  feat_out
);
	import ebn_pkg::*;

	logic [SF_W-1:0] smooth_factor_q;
	logic            push, full, pop, empty;
	band_rec_t       push_data, pop_data;

	// configuration: one register at word 0, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(smooth_factor_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_factor_q <= SF_W'(SF_RESET);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			smooth_factor_q <= pwdata[SF_W-1:0];
		end
	end

	// front: squaring and band accumulation
	ebn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_in    (bin_in),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// closed-band queue
	ebn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: dB, running mean, feature beat
	ebn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.smooth_factor (smooth_factor_q),
		.pop           (pop),
		.pop_data      (pop_data),
		.empty         (empty),
		.feat          (feat_out)
	);
endmodule

@@ tb/tb_erb_band_energy_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_erb_band_energy_normalizer
// Self-checking bench for the band energy normalizer: spectrum bins are
// streamed in bands and frames, each band-end beat is run through a local
// model of the log/mean/normalize chain, and every feature beat is compared
// in order against it. Phases sweep the smoothing alpha and handshake idling.
// ----------------------------------------------------------------------------
module tb_erb_band_energy_normalizer;
	import ebn_pkg::*;

	localparam logic [2:0] REG_SMOOTH = 3'd0;  // smooth_factor, byte offset 0
	localparam int IDLE_LIMIT = 20000;         // cycles with no beat before giving up
	localparam int DRAIN_PAD = 200;            // extra wait for the back end after the last expected feature

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          bend;
		logic                          fend;
	} bin_t;

	typedef struct {
		logic signed [FEAT_W-1:0] feature;
		logic [BNUM_W-1:0]        band;
		logic                     last;
	} feat_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	ebn_bin_if  bin_if();
	ebn_feat_if feat_if();

	erb_band_energy_normalizer uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.bin_in(bin_if), .feat_out(feat_if)
	);

	// bins waiting to be driven, features the model says are coming
	bin_t  bin_queue[$];
	feat_t feature_queue[$];

	// local model state
	longint unsigned power_acc;
	int              bins_in_band;
	int              cur_band;
	int              band_mean[NUM_BANDS];
	int              alpha;

	int  errors;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_off;
	bit  bin_taken;
	bit  finished;
	int  phase;
	int  quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the arithmetic
	// ------------------------------------------------------------------

	// log2 in Q16: top set bit, then 16 squarings of a Q1.30 mantissa
	function automatic longint log2_fix(longint unsigned v);
		int              p;
		longint unsigned m;
		longint          r;
		if (v == 0)
			return 0;
		p = 63;
		while (p > 0 && !v[p])
			p--;
		m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		r = longint'(p) <<< 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r = r | (longint'(1) <<< i);
			end
		end
		return r;
	endfunction

	// accumulate one bin; on a band end produce the expected feature beat
	task automatic accumulate_bin(bin_t b);
		longint          re, im, lg, db, nm, num, fq;
		longint unsigned pw;
		bit              close;
		feat_t           f;
		re = b.re;
		im = b.im;
		close = b.bend | b.fend;
		pw = longint'(re * re) + longint'(im * im);
		power_acc = (power_acc > ~64'd0 - pw) ? ~64'd0 : power_acc + pw;
		if (bins_in_band < MAX_BAND_BINS)
			bins_in_band++;
		if (!close)
			return;
		// mean power in dB, Q14, with the -100 dB floor
		if (power_acc == 0) begin
			db = DB_FLOOR;
		end else begin
			lg = log2_fix(power_acc) - log2_fix(longint'(bins_in_band))
				- (longint'(2 * (SAMPLE_BITS - 1)) <<< 16);
			db = (lg * TEN_LOG2 + 32768) >>> 16;
			if (db < DB_FLOOR)
				db = DB_FLOOR;
			if (db > DB_MAX)
				db = DB_MAX;
		end
		if (cur_band >= NUM_BANDS)
			cur_band = 0;
		// running mean update
		nm = (db * (65536 - alpha) + longint'(band_mean[cur_band]) * alpha + 32768) >>> 16;
		if (nm > DB_MAX)
			nm = DB_MAX;
		if (nm < DB_MIN)
			nm = DB_MIN;
		band_mean[cur_band] = int'(nm);
		// divide by 160 with floor
		num = db - nm + 80;
		fq = num / 160;
		if ((num % 160) != 0 && num < 0)
			fq--;
		if (fq > FEAT_MAX)
			fq = FEAT_MAX;
		if (fq < FEAT_MIN)
			fq = FEAT_MIN;
		f.feature = FEAT_W'(fq);
		f.band = BNUM_W'(cur_band);
		f.last = b.fend;
		feature_queue.push_back(f);
		power_acc = 0;
		bins_in_band = 0;
		if (b.fend || cur_band + 1 >= NUM_BANDS)
			cur_band = 0;
		else
			cur_band = cur_band + 1;
	endtask

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// single bin; amplitude style 0 full range, 1 tiny, 2 zero, 3 mid
	function automatic logic signed [SAMPLE_BITS-1:0] sample(int style);
		case (style)
			0: return SAMPLE_BITS'($urandom);
			1: return SAMPLE_BITS'($signed($urandom_range(8)) - 4);
			2: return '0;
			default: return SAMPLE_BITS'($signed($urandom_range(65535)) - 32768);
		endcase
	endfunction

	task automatic push_bin(logic signed [SAMPLE_BITS-1:0] re, logic signed [SAMPLE_BITS-1:0] im,
			bit bend, bit fend);
		bin_t b;
		b.re = re;
		b.im = im;
		b.bend = bend;
		b.fend = fend;
		bin_queue.push_back(b);
	endtask

	// one band of len bins with random content; the last bin closes it
	task automatic push_band(int len, bit fend);
		int style;
		bit bflag;
		style = $urandom_range(3);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1) begin
				// a frame end closes the band even with band_end low
				bflag = fend ? $urandom_range(1) : 1'b1;
				push_bin(sample(style), sample(style), bflag, fend);
			end else begin
				push_bin(sample(style), sample(style), 1'b0, 1'b0);
			end
		end
	endtask

	// random bands until about n bins are queued
	task automatic push_random(int n);
		int added, len, frame_odds;
		added = 0;
		frame_odds = $urandom_range(2, 60);
		while (added < n) begin
			case ($urandom_range(19))
				0: len = $urandom_range(60, 72);   // may run past the bin counter limit
				1, 2: len = $urandom_range(9, 30);
				default: len = $urandom_range(1, 8);
			endcase
			push_band(len, $urandom_range(frame_odds - 1) == 0);
			added += len;
			if ($urandom_range(15) == 0)
				frame_odds = $urandom_range(2, 60);
		end
	endtask

	// APB write: setup then access, beat lands when psel/penable/pwrite/pready all high
	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_SMOOTH)
			alpha = int'(data[SF_W-1:0]);
	endtask

	task automatic drain();
		wait (bin_queue.size() == 0 && !bin_if.valid && feature_queue.size() == 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// bin driver: new beat at the falling edge once the last one went in
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!bin_if.valid || bin_taken)) begin
			if (bin_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				bin_if.real_part <= bin_queue[0].re;
				bin_if.imag_part <= bin_queue[0].im;
				bin_if.band_end <= bin_queue[0].bend;
				bin_if.frame_end <= bin_queue[0].fend;
				bin_if.valid <= 1'b1;
				void'(bin_queue.pop_front());
			end else begin
				bin_if.valid <= 1'b0;
			end
		end
	end

	// feature receiver: random stalls, plus the long hold-off
	always @(negedge clk) begin
		feat_if.ready <= arst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// monitor: model runs on every accepted bin, features checked in order
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bin_taken <= bin_if.valid && bin_if.ready;
		if (bin_if.valid && bin_if.ready) begin
			bin_t b;
			b.re = bin_if.real_part;
			b.im = bin_if.imag_part;
			b.bend = bin_if.band_end;
			b.fend = bin_if.frame_end;
			accumulate_bin(b);
		end
		if (feat_if.valid && feat_if.ready) begin
			if (feature_queue.size() == 0) begin
				report("unexpected feature beat", feat_if.feature, 0);
			end else begin
				feat_t e;
				e = feature_queue.pop_front();
				if (feat_if.feature !== e.feature)
					report("feature", feat_if.feature, e.feature);
				if (feat_if.band_number !== e.band)
					report("band_number", feat_if.band_number, e.band);
				if (feat_if.last_of_frame !== e.last)
					report("last_of_frame", feat_if.last_of_frame, e.last);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((bin_if.valid && bin_if.ready) || (feat_if.valid && feat_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT && !finished) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver holds off long enough for the band queue to fill and stall bins
	initial begin
		hold_off = 1'b0;
		wait (phase == 1);
		repeat (50) @(negedge clk);
		hold_off = 1'b1;
		repeat (600) @(negedge clk);
		hold_off = 1'b0;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int alphas[5];
		errors = 0;
		finished = 1'b0;
		phase = 0;
		quiet_cycles = 0;
		bin_taken = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bin_if.valid = 1'b0;
		bin_if.real_part = '0;
		bin_if.imag_part = '0;
		bin_if.band_end = 1'b0;
		bin_if.frame_end = 1'b0;
		feat_if.ready = 1'b0;
		power_acc = 0;
		bins_in_band = 0;
		cur_band = 0;
		alpha = SF_RESET;
		for (int e = 0; e < NUM_BANDS; e++)
			band_mean[e] = $signed(MEAN_INIT[e]);
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme bins, zero and tiny power, short frames
		push_bin(-24'sd8388608, -24'sd8388608, 1'b1, 1'b0);
		push_bin(24'sd8388607, 24'sd8388607, 1'b1, 1'b0);
		push_bin(24'sd8388607, -24'sd8388608, 1'b0, 1'b0);
		push_bin(-24'sd8388608, 24'sd8388607, 1'b1, 1'b0);
		push_bin('0, '0, 1'b1, 1'b0);              // zero power hits the floor
		push_bin(24'sd1, '0, 1'b1, 1'b0);          // far below -100 dB
		push_bin('0, '0, 1'b0, 1'b0);
		push_bin(24'sd1, 24'sd1, 1'b0, 1'b1);      // frame end alone closes the band
		push_bin(24'sd4096, -24'sd4096, 1'b1, 1'b1);
		push_bin(-24'sd1, 24'sd2000000, 1'b1, 1'b0);
		push_bin(24'sd3000000, 24'sd5, 1'b1, 1'b1); // short frame
		for (int i = 0; i < 10; i++)
			push_bin(sample(0), sample(0), 1'b0, 1'b0);
		push_bin(sample(0), sample(0), 1'b1, 1'b0);

		alphas[0] = SF_RESET;
		alphas[1] = 0;
		alphas[2] = 65535;
		alphas[3] = $urandom_range(65535);
		alphas[4] = SF_RESET;
		for (int p = 0; p < 5; p++) begin
			phase = p;
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (p != 0)
				apb_write(REG_SMOOTH, 32'(alphas[p]));
			push_random(340);
			drain();
		end

		finished = 1'b1;
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
